### src/xmcrc_pkg.sv
`timescale 1ns / 1ps

package xmcrc_pkg;

	// Framing bytes and packet geometry.
	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] EOT_BYTE = 8'h04;
	localparam int unsigned PACKET_LEN = 133;
	localparam int unsigned PAYLOAD_LEN = 128;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Byte positions inside a packet.
	localparam logic [7:0] POS_SOH = 8'd0;
	localparam logic [7:0] POS_BLOCK = 8'd1;
	localparam logic [7:0] POS_COMPL = 8'd2;
	localparam logic [7:0] POS_DATA = 8'd3;
	localparam logic [7:0] POS_CRC_HI = 8'(PAYLOAD_LEN + 3);
	localparam logic [7:0] POS_LAST = 8'(PACKET_LEN - 1);

	// Ring geometry; the ring size must be a power of two.
	localparam int unsigned RING_BYTES = 1024;
	localparam int unsigned RING_AW = $clog2(RING_BYTES);
	localparam int unsigned ADDR_W = 10;

	// Reply codes sent back to the sender.
	localparam logic REPLY_ACK = 1'b0;
	localparam logic REPLY_NACK = 1'b1;

	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_GOOD = 2'd1,
		RES_DUP  = 2'd2,
		RES_BAD  = 2'd3
	} packet_res_t;

	// One result beat.
	typedef struct packed {
		logic              payload_valid;
		logic [7:0]        payload_byte;
		logic [ADDR_W-1:0] payload_addr;
		logic              reply_valid;
		logic              reply_code;
		packet_res_t       packet_result;
		logic              transfer_done;
	} result_t;

	// CRC-16 update for one byte, MSB first, eight shift steps.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### src/xmodem_crc_packet_receiver.sv
`timescale 1ns / 1ps

// XMODEM-CRC packet receiver.
// The input channel (in_valid, in_stall, rx_byte) takes one serial byte per beat.
// The output channel (out_valid, out_stall and the result fields) gives exactly
// one result beat for every input beat, in order. Payload bytes come out as they
// arrive with their ring address; the last byte of a 133-byte packet carries the
// verdict and the ACK/NACK reply; an EOT in place of SOH ends the transfer.
// A byte accepted into the input register passes through the result register
// before its result shows on out_valid.
// Throughput: one byte per cycle while the output is not stalled; the CRC
// update for a byte is combinational logic between the input and result registers.
// When the output is stalled, the result register holds and the input register
// keeps one more byte; in_stall then rises until the result beat is taken.
// Reset (arst_n low) clears the packet counter, block number, ring base, the
// transfer-done flag and both valid flags.

module xmodem_crc_packet_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          payload_valid,
	output logic [7:0]                    payload_byte,
	output logic [xmcrc_pkg::ADDR_W-1:0]  payload_addr,
	output logic                          reply_valid,
	output logic                          reply_code,
	output logic [1:0]                    packet_result,
	output logic                          transfer_done
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               out_valid_q;
	xmcrc_pkg::result_t out_q;
	xmcrc_pkg::result_t res;
	logic               out_free;
	logic               step;

	// The result register can load when empty or when its beat leaves.
	assign out_free = !out_valid_q || !out_stall;
	assign step = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	xmcrc_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.data   (byte_s1),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign payload_valid = out_q.payload_valid;
	assign payload_byte = out_q.payload_byte;
	assign payload_addr = out_q.payload_addr;
	assign reply_valid = out_q.reply_valid;
	assign reply_code = out_q.reply_code;
	assign packet_result = out_q.packet_result;
	assign transfer_done = out_q.transfer_done;

endmodule

### src/xmcrc_frame.sv
`timescale 1ns / 1ps

module xmcrc_frame (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data,
	output xmcrc_pkg::result_t res
);

	logic [7:0]                   byte_count_q;
	logic [7:0]                   last_block_q;
	logic                         start_ok_q;
	logic [7:0]                   block_number_q;
	logic [7:0]                   block_compl_q;
	logic [15:0]                  crc_acc_q;
	logic [7:0]                   crc_high_q;
	logic [xmcrc_pkg::RING_AW-1:0] ring_position_q;
	logic                         finished_q;

	logic [7:0]                   byte_count_d;
	logic [7:0]                   last_block_d;
	logic                         start_ok_d;
	logic [7:0]                   block_number_d;
	logic [7:0]                   block_compl_d;
	logic [15:0]                  crc_acc_d;
	logic [7:0]                   crc_high_d;
	logic [xmcrc_pkg::RING_AW-1:0] ring_position_d;
	logic                         finished_d;

	logic [xmcrc_pkg::RING_AW-1:0] ring_addr;
	logic [7:0]                   data_offset;
	logic                         compl_ok;
	logic                         crc_ok;
	logic                         hdr_ok;

	// Payload address and packet checks.
	assign data_offset = byte_count_q - xmcrc_pkg::POS_DATA;
	assign ring_addr = ring_position_q + xmcrc_pkg::RING_AW'(data_offset);
	assign compl_ok = (block_compl_q == ~block_number_q);
	assign crc_ok = (crc_high_q == crc_acc_q[15:8]) && (data == crc_acc_q[7:0]);
	assign hdr_ok = start_ok_q && compl_ok;

	// Next state and the result of the current byte.
	always_comb begin
		byte_count_d = byte_count_q;
		last_block_d = last_block_q;
		start_ok_d = start_ok_q;
		block_number_d = block_number_q;
		block_compl_d = block_compl_q;
		crc_acc_d = crc_acc_q;
		crc_high_d = crc_high_q;
		ring_position_d = ring_position_q;
		finished_d = finished_q;
		res = '0;
		res.packet_result = xmcrc_pkg::RES_NONE;

		if (!finished_q) begin
			if (byte_count_q == xmcrc_pkg::POS_SOH && data == xmcrc_pkg::EOT_BYTE) begin
				finished_d = 1'b1;
				res.reply_valid = 1'b1;
				res.reply_code = xmcrc_pkg::REPLY_ACK;
			end else begin
				if (byte_count_q == xmcrc_pkg::POS_SOH) begin
					start_ok_d = (data == xmcrc_pkg::SOH_BYTE);
					crc_acc_d = '0;
				end else if (byte_count_q == xmcrc_pkg::POS_BLOCK) begin
					block_number_d = data;
				end else if (byte_count_q == xmcrc_pkg::POS_COMPL) begin
					block_compl_d = data;
				end else if (byte_count_q < xmcrc_pkg::POS_CRC_HI) begin
					res.payload_valid = 1'b1;
					res.payload_byte = data;
					res.payload_addr = xmcrc_pkg::ADDR_W'(ring_addr);
					crc_acc_d = xmcrc_pkg::crc_update(crc_acc_q, data);
				end else if (byte_count_q == xmcrc_pkg::POS_CRC_HI) begin
					crc_high_d = data;
				end else begin
					res.reply_valid = 1'b1;
					if (hdr_ok && block_number_q == last_block_q) begin
						res.packet_result = xmcrc_pkg::RES_DUP;
						res.reply_code = xmcrc_pkg::REPLY_ACK;
					end else if (hdr_ok && block_number_q == last_block_q + 8'd1 && crc_ok) begin
						res.packet_result = xmcrc_pkg::RES_GOOD;
						res.reply_code = xmcrc_pkg::REPLY_ACK;
						last_block_d = last_block_q + 8'd1;
						ring_position_d = ring_position_q
							+ xmcrc_pkg::RING_AW'(xmcrc_pkg::PAYLOAD_LEN);
					end else begin
						res.packet_result = xmcrc_pkg::RES_BAD;
						res.reply_code = xmcrc_pkg::REPLY_NACK;
					end
				end

				// The packet counter wraps after the last CRC byte.
				if (byte_count_q == xmcrc_pkg::POS_LAST) begin
					byte_count_d = '0;
				end else begin
					byte_count_d = byte_count_q + 8'd1;
				end
			end
		end
		res.transfer_done = finished_d;
	end

	// Packet state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			last_block_q <= '0;
			start_ok_q <= 1'b0;
			block_number_q <= '0;
			block_compl_q <= '0;
			crc_acc_q <= '0;
			crc_high_q <= '0;
			ring_position_q <= '0;
			finished_q <= 1'b0;
		end else if (step) begin
			byte_count_q <= byte_count_d;
			last_block_q <= last_block_d;
			start_ok_q <= start_ok_d;
			block_number_q <= block_number_d;
			block_compl_q <= block_compl_d;
			crc_acc_q <= crc_acc_d;
			crc_high_q <= crc_high_d;
			ring_position_q <= ring_position_d;
			finished_q <= finished_d;
		end
	end

	// The packet counter never leaves the packet.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= xmcrc_pkg::POS_LAST)
		else $error("packet byte counter out of range");

	// Once the transfer has ended it stays ended.
	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("transfer end flag dropped");

	// A good verdict moves the ring base by one payload.
	a_ring_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.packet_result == xmcrc_pkg::RES_GOOD |=>
		ring_position_q == $past(ring_position_q)
			+ xmcrc_pkg::RING_AW'(xmcrc_pkg::PAYLOAD_LEN))
		else $error("ring base did not advance after a good packet");

	// The counter only changes on a processed byte.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(byte_count_q))
		else $error("packet counter moved without a byte");

endmodule
